>>> hdl/distinct_multiset_subset_generator_macros.svh
// Assertion macros used by the subset generator RTL.
`ifndef DISTINCT_MULTISET_SUBSET_GENERATOR_MACROS_SVH
`define DISTINCT_MULTISET_SUBSET_GENERATOR_MACROS_SVH

// Condition that must hold at every rising clock edge outside reset.
`define DMSG_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DMSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/dmsg_pkg.sv
// Types, codes and sizes for the distinct sub-multiset generator.
package dmsg_pkg;

   localparam int VALUE_BITS        = 16;
   localparam int MAX_ITEMS_DEFAULT = 16;

   // Operation codes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_NEXT  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]                   operation;
      logic signed [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] element;
      logic                         empty_subset;
      logic                         last_in_subset;
      logic                         last_subset;
      logic                         exhausted;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_ADV_TOP,
      ST_ADV_CHK,
      ST_BT_POS,
      ST_BT_VAL,
      ST_BT_CMP,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_LST_RD0,
      ST_LST_RD1,
      ST_LST_CHK,
      ST_EM_RD,
      ST_EM_VAL,
      ST_EM_OUT
   } state_type;

endpackage

>>> hdl/distinct_multiset_subset_generator.sv
// Distinct sub-multiset generator: sorted value store and depth-first subset walker.
//
// Channel   Ports                         Handshake
// --------  ----------------------------  -----------------------------------------
// request   start, busy, req_data         taken when start is high and busy is low
// result    rsp_valid, rsp_data           one-cycle strobe, cannot be held off
//
// Load: each larger stored value is moved up one slot, then the new value is written.
// Next: opening empty subset and repeat exhausted results come straight from idle; else
// descend, or backtrack level by level and scan past duplicates, then check for the last
// subset and emit one element per result through the registered-read memories.
// Reset is synchronous and clears control state only; no clearing pass.
// Results are never stalled; busy drops as the last result of a transaction appears.
module distinct_multiset_subset_generator
   import dmsg_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

`include "distinct_multiset_subset_generator_macros.svh"

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

   // Control state
   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic          started_ff, started_in;
   logic          finished_ff, finished_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic signed [VALUE_BITS-1:0] vmax_ff, vmax_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic signed [VALUE_BITS-1:0] qval_ff, qval_in;
   logic [CW-1:0] ins_idx_ff, ins_idx_in;
   logic [CW-1:0] lvl_ff, lvl_in;
   logic [CW-1:0] k_ff, k_in;
   logic [AW-1:0] q_ff, q_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic          last_ff, last_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // Memories
   logic signed [VALUE_BITS-1:0] sorted_vals_ff [MAX_ITEMS];
   logic [AW-1:0]                chosen_pos_ff  [MAX_ITEMS];
   logic signed [VALUE_BITS-1:0] val_rd_ff;
   logic [AW-1:0]                pos_rd_ff;

   logic                         val_we;
   logic [AW-1:0]                val_waddr, val_raddr;
   logic signed [VALUE_BITS-1:0] val_wdata;
   logic                         pos_we;
   logic [AW-1:0]                pos_waddr, pos_raddr, pos_wdata;

   // Decremented counters and widened read position for addressing
   logic [CW-1:0] depth_m1, lvl_m1, ins_m1, pos_rd_ext;
   assign depth_m1   = depth_ff - 1'b1;
   assign lvl_m1     = lvl_ff - 1'b1;
   assign ins_m1     = ins_idx_ff - 1'b1;
   assign pos_rd_ext = CW'(pos_rd_ff);

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Value memory, registered read
   always_ff @(posedge clock) begin
      if (val_we) begin
         sorted_vals_ff[val_waddr] <= val_wdata;
      end
      val_rd_ff <= sorted_vals_ff[val_raddr];
   end

   // Chosen-position memory, registered read
   always_ff @(posedge clock) begin
      if (pos_we) begin
         chosen_pos_ff[pos_waddr] <= pos_wdata;
      end
      pos_rd_ff <= chosen_pos_ff[pos_raddr];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.operation)
                  OP_LOAD: begin
                     if (count_ff < MAX_CNT) state_in = ST_INS_RD;
                  end
                  OP_NEXT: begin
                     if (!finished_ff && started_ff) state_in = ST_ADV_TOP;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_RD:   state_in = (ins_idx_ff == '0) ? ST_IDLE : ST_INS_CMP;
         ST_INS_CMP:  state_in = (val_rd_ff > value_ff) ? ST_INS_RD : ST_IDLE;
         ST_ADV_TOP: begin
            if (depth_ff == '0) state_in = (count_ff != '0) ? ST_LST_RD0 : ST_IDLE;
            else                state_in = ST_ADV_CHK;
         end
         ST_ADV_CHK:  state_in = (pos_rd_ext + 1'b1 < count_ff) ? ST_LST_RD0 : ST_BT_POS;
         ST_BT_POS:   state_in = (lvl_ff == '0) ? ST_IDLE : ST_BT_VAL;
         ST_BT_VAL:   state_in = ST_BT_CMP;
         ST_BT_CMP:   state_in = (val_rd_ff == vmax_ff) ? ST_BT_POS : ST_SCAN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = (val_rd_ff != qval_ff) ? ST_LST_RD0 : ST_SCAN_RD;
         ST_LST_RD0:  state_in = ST_LST_RD1;
         ST_LST_RD1:  state_in = ST_LST_CHK;
         ST_LST_CHK:  state_in = ST_EM_RD;
         ST_EM_RD:    state_in = ST_EM_VAL;
         ST_EM_VAL:   state_in = ST_EM_OUT;
         ST_EM_OUT:   state_in = (k_ff + 1'b1 == depth_ff) ? ST_IDLE : ST_EM_RD;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory ports and results
   always_comb begin
      count_in     = count_ff;
      depth_in     = depth_ff;
      started_in   = started_ff;
      finished_in  = finished_ff;
      vmax_in      = vmax_ff;
      value_in     = value_ff;
      qval_in      = qval_ff;
      ins_idx_in   = ins_idx_ff;
      lvl_in       = lvl_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      scan_in      = scan_ff;
      last_in      = last_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      val_we       = 1'b0;
      val_waddr    = ins_idx_ff[AW-1:0];
      val_wdata    = value_ff;
      val_raddr    = '0;
      pos_we       = 1'b0;
      pos_waddr    = depth_ff[AW-1:0];
      pos_wdata    = '0;
      pos_raddr    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.operation)
                  OP_LOAD: begin
                     value_in   = req_data.value;
                     ins_idx_in = count_ff;
                  end
                  OP_NEXT: begin
                     if (finished_ff) begin
                        rsp_valid_in          = 1'b1;
                        rsp_data_in.exhausted = 1'b1;
                     end else if (!started_ff) begin
                        // first request: empty subset
                        started_in                 = 1'b1;
                        depth_in                   = '0;
                        rsp_valid_in               = 1'b1;
                        rsp_data_in.empty_subset   = 1'b1;
                        rsp_data_in.last_in_subset = 1'b1;
                        rsp_data_in.last_subset    = (count_ff == '0);
                     end
                  end
                  OP_CLEAR: begin
                     count_in    = '0;
                     depth_in    = '0;
                     started_in  = 1'b0;
                     finished_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         // Insertion: shift larger values up one slot at a time
         ST_INS_RD: begin
            if (ins_idx_ff == '0) begin
               val_we      = 1'b1;
               count_in    = count_ff + 1'b1;
               depth_in    = '0;
               started_in  = 1'b0;
               finished_in = 1'b0;
               if (count_ff == '0 || value_ff > vmax_ff) vmax_in = value_ff;
            end else begin
               val_raddr = ins_m1[AW-1:0];
            end
         end
         ST_INS_CMP: begin
            val_we = 1'b1;
            if (val_rd_ff > value_ff) begin
               val_wdata  = val_rd_ff;
               ins_idx_in = ins_m1;
            end else begin
               count_in    = count_ff + 1'b1;
               depth_in    = '0;
               started_in  = 1'b0;
               finished_in = 1'b0;
               if (count_ff == '0 || value_ff > vmax_ff) vmax_in = value_ff;
            end
         end
         // Descend one level if a later position exists; else report exhaustion or backtrack
         ST_ADV_TOP: begin
            if (depth_ff == '0) begin
               if (count_ff != '0) begin
                  pos_we   = 1'b1;
                  depth_in = CW'(1);
               end else begin
                  finished_in           = 1'b1;
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.exhausted = 1'b1;
               end
            end else begin
               pos_raddr = depth_m1[AW-1:0];
            end
         end
         ST_ADV_CHK: begin
            if (pos_rd_ext + 1'b1 < count_ff) begin
               pos_we    = 1'b1;
               pos_wdata = pos_rd_ff + 1'b1;
               depth_in  = depth_ff + 1'b1;
            end else begin
               lvl_in = depth_ff;
            end
         end
         // Backtrack: pop levels whose value is already the maximum; exhausted when none remain
         ST_BT_POS: begin
            if (lvl_ff == '0) begin
               finished_in           = 1'b1;
               depth_in              = '0;
               rsp_valid_in          = 1'b1;
               rsp_data_in.exhausted = 1'b1;
            end else begin
               pos_raddr = lvl_m1[AW-1:0];
            end
         end
         ST_BT_VAL: begin
            q_in      = pos_rd_ff;
            val_raddr = pos_rd_ff;
         end
         ST_BT_CMP: begin
            if (val_rd_ff == vmax_ff) begin
               lvl_in = lvl_m1;
            end else begin
               qval_in = val_rd_ff;
               scan_in = q_ff + 1'b1;
            end
         end
         // Skip duplicates to the first strictly larger value
         ST_SCAN_RD: begin
            val_raddr = scan_ff;
         end
         ST_SCAN_CMP: begin
            if (val_rd_ff != qval_ff) begin
               pos_we    = 1'b1;
               pos_waddr = lvl_m1[AW-1:0];
               pos_wdata = scan_ff;
               depth_in  = lvl_ff;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         // Last subset: deepest position at the end and smallest chosen value is max
         ST_LST_RD0: begin
            pos_raddr = '0;
         end
         ST_LST_RD1: begin
            val_raddr = pos_rd_ff;
            pos_raddr = depth_m1[AW-1:0];
         end
         ST_LST_CHK: begin
            last_in = (val_rd_ff == vmax_ff) && (pos_rd_ext + 1'b1 == count_ff);
            k_in    = '0;
         end
         // Emission, one element per result
         ST_EM_RD: begin
            pos_raddr = k_ff[AW-1:0];
         end
         ST_EM_VAL: begin
            val_raddr = pos_rd_ff;
         end
         ST_EM_OUT: begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.element        = val_rd_ff;
            rsp_data_in.last_in_subset = (k_ff + 1'b1 == depth_ff);
            rsp_data_in.last_subset    = last_ff;
            k_in                       = k_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         depth_ff     <= '0;
         started_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         started_ff   <= started_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      vmax_ff     <= vmax_in;
      value_ff    <= value_in;
      qval_ff     <= qval_in;
      ins_idx_ff  <= ins_idx_in;
      lvl_ff      <= lvl_in;
      k_ff        <= k_in;
      q_ff        <= q_in;
      scan_ff     <= scan_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Assertions
   logic done_next, full_load, exh_out;
   assign done_next = start && !busy && req_data.operation == OP_NEXT && finished_ff;
   assign full_load = start && !busy && req_data.operation == OP_LOAD && count_ff == MAX_CNT;
   assign exh_out   = rsp_valid && rsp_data.exhausted;

   `DMSG_ASSERT_ALWAYS(a_depth_le_count, clock, reset, depth_ff <= count_ff, "depth over count")
   `DMSG_ASSERT_ALWAYS(a_done_empty, clock, reset, !finished_ff || depth_ff == '0, "depth kept")
   `DMSG_ASSERT_NEXT(a_exh_reply, clock, reset, done_next, exh_out, "no exhausted")
   `DMSG_ASSERT_NEXT(a_full_ld, clock, reset, full_load, !busy && $stable(count_ff), "load taken")

endmodule
